FILE: hw/rtl/circular_deque_store_assert.svh
// Assertion macros shared by the circular deque store RTL.
`ifndef CIRCULAR_DEQUE_STORE_ASSERT_SVH
`define CIRCULAR_DEQUE_STORE_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define CDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define CDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cds_pkg.sv
// Types and constants shared by the circular deque store modules.
`default_nettype none

package cds_pkg;

  // Store geometry; the capacity is a power of two so slot arithmetic wraps naturally.
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned PTR_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = PTR_W + 1;

  // Transaction field widths.
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_BITS  = FUNC_W + VALUE_W + INDEX_W;
  localparam int unsigned OUT_BITS = VALUE_W + COUNT_W + STATUS_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Value returned by a read past the element count.
  localparam logic [VALUE_W-1:0] ERR_VALUE = 32'h8000_0015;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_BACK  = 3'd0,
    FUNC_PUSH_FRONT = 3'd1,
    FUNC_POP_BACK   = 3'd2,
    FUNC_POP_FRONT  = 3'd3,
    FUNC_READ       = 3'd4
  } cds_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } cds_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted input transaction
    logic exec;     // apply the operation, issue store access
    logic finish;   // load the result register
  } cds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register empty or drained this cycle
  } cds_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cds_ctrl.sv
// Controller state machine sequencing one deque operation at a time.
`default_nettype none

module cds_ctrl
  import cds_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_axis_tvalid,
  output logic           s_axis_tready,
  input  wire cds_stat_t stat_i,
  output cds_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WRAP = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Take a transaction only when the result register can receive its answer.
  assign s_axis_tready = (state_q == ST_IDLE) && stat_i.out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Drive datapath commands.
  assign cmd_o.capture = accept;
  assign cmd_o.exec    = (state_q == ST_EXEC);
  assign cmd_o.finish  = (state_q == ST_WRAP);

  // Advance the sequence.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_WRAP;
      ST_WRAP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cds_dp.sv
// Datapath: element store, front pointer, element count and result register.
`default_nettype none

module cds_dp
  import cds_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cds_cmd_t               cmd_i,
  output cds_stat_t                   stat_o,
  input  wire logic [IN_TDATA_W-1:0]  in_data_i,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  // Captured transaction.
  logic [FUNC_W-1:0]  func_q;
  logic [ELEM_W-1:0]  value_q;
  logic [INDEX_W-1:0] index_q;

  // Deque state.
  logic [PTR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Element store and its registered read port.
  logic [ELEM_W-1:0] store_q [CAPACITY];
  logic [ELEM_W-1:0] rd_data_q;
  logic [PTR_W-1:0]  rd_addr;
  logic [PTR_W-1:0]  wr_addr;
  logic              wr_en;

  // Per-operation outcome held between execute and finish.
  cds_status_e status_q, status_d;
  logic        use_rd_q, use_rd_d;

  // Result register.
  logic                out_valid_q;
  logic [VALUE_W-1:0]  out_data_q;
  logic [COUNT_W-1:0]  out_count_q;
  cds_status_e         out_status_q;

  logic is_full, is_empty, in_range;

  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign in_range = ({1'b0, index_q} < count_q);
  assign rd_addr  = front_q + index_q;

  // Decode the operation and compute the next pointer and count.
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    wr_en    = 1'b0;
    wr_addr  = front_q + count_q[PTR_W-1:0];
    status_d = STAT_OK;
    use_rd_d = 1'b0;
    case (func_q)
      FUNC_PUSH_BACK: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      FUNC_PUSH_FRONT: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          front_d = front_q - PTR_W'(1);
          wr_addr = front_q - PTR_W'(1);
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      FUNC_POP_BACK: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      FUNC_POP_FRONT: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          front_d = front_q + PTR_W'(1);
          count_d = count_q - CNT_W'(1);
        end
      end
      FUNC_READ: begin
        if (in_range) begin
          use_rd_d = 1'b1;
        end else begin
          status_d = STAT_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // Capture the input transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= in_data_i[FUNC_W-1:0];
      value_q <= in_data_i[FUNC_W +: VALUE_W];
      index_q <= in_data_i[FUNC_W + VALUE_W +: INDEX_W];
    end
  end

  // Hold the store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      store_q[wr_addr] <= value_q;
    end
    rd_data_q <= store_q[rd_addr];
  end

  // Keep the outcome of the operation for the finish step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      use_rd_q <= use_rd_d;
    end
  end

  // Update pointer and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Load the result and drop it once the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (use_rd_q) begin
        out_data_q <= rd_data_q;
      end else if (status_q == STAT_RANGE) begin
        out_data_q <= ERR_VALUE;
      end else begin
        out_data_q <= '0;
      end
      out_count_q  <= COUNT_W'(count_q);
      out_status_q <= status_q;
    end
  end

  assign stat_o.out_free = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                            out_status_q, out_count_q, out_data_q};

endmodule

`default_nettype wire

FILE: hw/rtl/circular_deque_store.sv
// Circular deque store: a 1024-entry double-ended queue of 32-bit elements on
// streaming ports. Each input transaction pushes at the back or front, pops
// from the back or front, or reads the element at an index counted from the
// front, and yields exactly one result transaction with the read value, the
// element count after the operation and a status (ok, full, empty, out of
// range). Operations run one at a time: a transaction passes from acceptance
// to its result through capture, store access with a registered read and
// result load, and no new transaction is taken before that result is loaded.
// The next transaction is accepted in the cycle its predecessor's result is
// taken. The store is not cleared at reset; only elements that pushes have
// written can be read.
`default_nettype none
`include "circular_deque_store_assert.svh"

module circular_deque_store
  import cds_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // [2:0] func, [34:3] value, [44:35] index, [47:45] zero
  input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // [31:0] read_data, [42:32] count, [44:43] status, [47:45] zero
  output logic [OUT_TDATA_W-1:0]       m_axis_tdata
);

  cds_cmd_t  cmd;
  cds_stat_t stat;

  cds_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  cds_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_data_i     (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Result fields for checking.
  logic [COUNT_W-1:0]  chk_count;
  logic [STATUS_W-1:0] chk_status;

  assign chk_count  = m_axis_tdata[VALUE_W +: COUNT_W];
  assign chk_status = m_axis_tdata[VALUE_W + COUNT_W +: STATUS_W];

  `CDS_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "second transaction accepted while one is in flight")
  `CDS_ASSERT_SAME(a_count_bound, m_axis_tvalid, chk_count <= COUNT_W'(CAPACITY),
    "element count exceeds capacity")
  `CDS_ASSERT_SAME(a_full_count, m_axis_tvalid && (chk_status == STAT_FULL),
    chk_count == COUNT_W'(CAPACITY), "full refusal with store not full")
  `CDS_ASSERT_SAME(a_empty_count, m_axis_tvalid && (chk_status == STAT_EMPTY),
    chk_count == '0, "empty refusal with store not empty")

endmodule

`default_nettype wire
